@@ hw/rtl/particle_lifetime_update_macros.svh @@
// Assertion macros shared by the particle update RTL.
// Needs a clock i_clk and an active-low reset i_rst_n in the using module.
`ifndef PARTICLE_LIFETIME_UPDATE_MACROS_SVH
`define PARTICLE_LIFETIME_UPDATE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PLU_ASSERT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PLU_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ hw/rtl/plu_pkg.sv @@
// Types, register codes and saturation helper for the particle update block.
// No dependencies.
package plu_pkg;

    typedef logic [2:0] t_cfg_idx;

    localparam t_cfg_idx CFG_GRAV_X     = 3'd0;
    localparam t_cfg_idx CFG_GRAV_Y     = 3'd1;
    localparam t_cfg_idx CFG_GRAV_Z     = 3'd2;
    localparam t_cfg_idx CFG_SIZE_EN    = 3'd3;
    localparam t_cfg_idx CFG_KEY_COUNT  = 3'd4;
    localparam t_cfg_idx CFG_KEY_TIMES  = 3'd5;
    localparam t_cfg_idx CFG_KEY_VALUES = 3'd6;

    localparam logic [2:0]         MAX_KEYS   = 3'd4;
    localparam logic [31:0]        GRAV_Y_RST = 32'hFFF6_3334; // -642252
    localparam logic signed [17:0] ONE_Q8_8   = 18'sd256;
    localparam logic [30:0]        AGE_MAX    = 31'h7FFF_FFFF;

    // particle record as it travels down the pipe
    typedef struct packed {
        logic              alive;
        logic [30:0]       nage;
        logic [2:0][31:0]  pos;
        logic [2:0][31:0]  vel;
        logic [31:0]       size;
    } t_rec;

    // curve decision that rides along with the record
    typedef struct packed {
        t_rec        rec;
        logic        apply;
        logic        interp;
        logic        neg;
        logic [17:0] fc;
        logic [15:0] v0;
    } t_curve;

    // interpolation segment operands
    typedef struct packed {
        logic [16:0] dv;
        logic [15:0] dtk;
        logic [15:0] w;
    } t_seg;

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'h8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

@@ hw/rtl/particle_lifetime_update.sv @@
// Top level of the particle update pipeline: config registers and stages.
// Depends on plu_pkg, plu_div and the assertion macros header.
//
// One particle record enters per clock and the pipe sustains one word per cycle
// while the output is not stalled. Each stage has its own valid bit and takes a
// new word whenever it is empty or its successor moves, so bubbles close up
// during an output stall. The pipe is built from the two dividers (normalized
// age and curve interpolation), each resolving one quotient bit per stage over
// 16 stages, plus four motion stages, two curve-select stages and three size
// stages. Config writes are always accepted and must only happen while the
// pipe is empty.
`include "particle_lifetime_update_macros.svh"

module particle_lifetime_update (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [30:0]        i_step_time,
    input  logic [30:0]        i_age,
    input  logic [30:0]        i_life_span,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic signed [31:0] i_vel_z,
    input  logic signed [31:0] i_initial_size,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_alive,
    output logic [30:0]        o_new_age,
    output logic signed [31:0] o_new_pos_x,
    output logic signed [31:0] o_new_pos_y,
    output logic signed [31:0] o_new_pos_z,
    output logic signed [31:0] o_new_vel_x,
    output logic signed [31:0] o_new_vel_y,
    output logic signed [31:0] o_new_vel_z,
    output logic signed [31:0] o_new_size
);

    // ---------------- config registers ----------------
    logic [2:0][31:0] r_grav;
    logic             r_size_en;
    logic [2:0]       r_key_cnt;
    logic [63:0]      r_key_times;
    logic [63:0]      r_key_vals;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav[0]   <= '0;
            r_grav[1]   <= plu_pkg::GRAV_Y_RST;
            r_grav[2]   <= '0;
            r_size_en   <= 1'b0;
            r_key_cnt   <= '0;
            r_key_times <= '0;
            r_key_vals  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                plu_pkg::CFG_GRAV_X:     r_grav[0]   <= i_cfg_data[31:0];
                plu_pkg::CFG_GRAV_Y:     r_grav[1]   <= i_cfg_data[31:0];
                plu_pkg::CFG_GRAV_Z:     r_grav[2]   <= i_cfg_data[31:0];
                plu_pkg::CFG_SIZE_EN:    r_size_en   <= i_cfg_data[0];
                plu_pkg::CFG_KEY_COUNT:  r_key_cnt   <= i_cfg_data[2:0];
                plu_pkg::CFG_KEY_TIMES:  r_key_times <= i_cfg_data;
                plu_pkg::CFG_KEY_VALUES: r_key_vals  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- stage enables ----------------
    logic en_a, en_b, en_c, en_d, en_e, en_f, en_g, en_h, en_o;
    logic w_d1_rdy, w_d2_rdy;
    logic r_vld_a, r_vld_b, r_vld_c, r_vld_d, r_vld_e, r_vld_f, r_vld_g, r_vld_h, r_vld_o;

    assign en_o = !r_vld_o || i_out_ready;
    assign en_h = !r_vld_h || en_o;
    assign en_g = !r_vld_g || en_h;
    assign en_f = !r_vld_f || w_d2_rdy;
    assign en_e = !r_vld_e || en_f;
    assign en_d = !r_vld_d || w_d1_rdy;
    assign en_c = !r_vld_c || en_d;
    assign en_b = !r_vld_b || en_c;
    assign en_a = !r_vld_a || en_b;
    assign o_in_ready = en_a;

    // ---------------- stage A: age, alive, gravity product ----------------
    plu_pkg::t_rec    r_a;
    logic [30:0]      r_a_dt, r_a_life;
    logic [2:0][63:0] r_a_gdt;
    logic [31:0]      w_age_sum;
    logic [30:0]      w_nage;
    logic [2:0][63:0] w_gdt;

    assign w_age_sum = {1'b0, i_age} + {1'b0, i_step_time};
    assign w_nage    = w_age_sum[31] ? plu_pkg::AGE_MAX : w_age_sum[30:0];

    for (genvar k = 0; k < 3; k++) begin : g_grav
        logic signed [63:0] w_prod;
        assign w_prod   = $signed(r_grav[k]) * $signed({1'b0, i_step_time});
        assign w_gdt[k] = w_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
        end else if (en_a) begin
            r_vld_a <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a && i_in_valid) begin
            r_a.alive <= w_nage < i_life_span;
            r_a.nage  <= w_nage;
            r_a.pos   <= {i_pos_z, i_pos_y, i_pos_x};
            r_a.vel   <= {i_vel_z, i_vel_y, i_vel_x};
            r_a.size  <= i_initial_size;
            r_a_dt    <= i_step_time;
            r_a_life  <= i_life_span;
            r_a_gdt   <= w_gdt;
        end
    end

    // ---------------- stage B: velocity update ----------------
    plu_pkg::t_rec    r_b;
    logic [30:0]      r_b_dt, r_b_life;
    logic [2:0][31:0] w_vel_b;

    for (genvar k = 0; k < 3; k++) begin : g_vel
        logic signed [63:0] w_vext, w_gsh, w_sum;
        assign w_vext = $signed({{32{r_a.vel[k][31]}}, r_a.vel[k]});
        assign w_gsh  = $signed(r_a_gdt[k]) >>> 16;
        assign w_sum  = w_vext + w_gsh;
        assign w_vel_b[k] = r_a.alive ? plu_pkg::sat32(w_sum) : r_a.vel[k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_b <= 1'b0;
        end else if (en_b) begin
            r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b && r_vld_a) begin
            r_b       <= {r_a.alive, r_a.nage, r_a.pos, w_vel_b, r_a.size};
            r_b_dt    <= r_a_dt;
            r_b_life  <= r_a_life;
        end
    end

    // ---------------- stage C: velocity times step ----------------
    plu_pkg::t_rec    r_c;
    logic [30:0]      r_c_life;
    logic [2:0][63:0] r_c_vdt;
    logic [2:0][63:0] w_vdt;

    for (genvar k = 0; k < 3; k++) begin : g_vdt
        logic signed [63:0] w_prod;
        assign w_prod   = $signed(r_b.vel[k]) * $signed({1'b0, r_b_dt});
        assign w_vdt[k] = w_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_c <= 1'b0;
        end else if (en_c) begin
            r_vld_c <= r_vld_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_c && r_vld_b) begin
            r_c      <= r_b;
            r_c_life <= r_b_life;
            r_c_vdt  <= w_vdt;
        end
    end

    // ---------------- stage D: position update ----------------
    plu_pkg::t_rec    r_d;
    logic [30:0]      r_d_life;
    logic [2:0][31:0] w_pos_d;

    for (genvar k = 0; k < 3; k++) begin : g_pos
        logic signed [63:0] w_pext, w_vsh, w_sum;
        assign w_pext = $signed({{32{r_c.pos[k][31]}}, r_c.pos[k]});
        assign w_vsh  = $signed(r_c_vdt[k]) >>> 16;
        assign w_sum  = w_pext + w_vsh;
        assign w_pos_d[k] = r_c.alive ? plu_pkg::sat32(w_sum) : r_c.pos[k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_d <= 1'b0;
        end else if (en_d) begin
            r_vld_d <= r_vld_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_d && r_vld_c) begin
            r_d      <= {r_c.alive, r_c.nage, w_pos_d, r_c.vel, r_c.size};
            r_d_life <= r_c_life;
        end
    end

    // ---------------- normalized age: (nage << 16) / life ----------------
    logic          w_d1_vld;
    logic [15:0]   w_d1_q;
    plu_pkg::t_rec w_d1_rec;

    plu_div #(
        .DW (31),
        .QW (16),
        .PW ($bits(plu_pkg::t_rec))
    ) u_div_age (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld_d),
        .o_ready (w_d1_rdy),
        .i_rem   (r_d.nage),
        .i_num   (16'd0),
        .i_den   (r_d_life),
        .i_side  (r_d),
        .o_valid (w_d1_vld),
        .i_ready (en_e),
        .o_quo   (w_d1_q),
        .o_side  (w_d1_rec)
    );

    // ---------------- stage E: curve key search ----------------
    plu_pkg::t_curve r_e_cv;
    plu_pkg::t_seg   r_e_seg;
    plu_pkg::t_curve n_e_cv;
    plu_pkg::t_seg   n_e_seg;

    always_comb begin
        logic [3:0][15:0]  kt;
        logic [3:0][15:0]  kv;
        logic [2:0]        cnt;
        logic [1:0]        lst;
        logic [1:0]        sel;
        logic [1:0]        prv;
        logic signed [16:0] wd;
        logic [15:0]       t;

        kt  = r_key_times;
        kv  = r_key_vals;
        t   = w_d1_q;
        cnt = (r_key_cnt > plu_pkg::MAX_KEYS) ? plu_pkg::MAX_KEYS : r_key_cnt;
        lst = 2'(cnt - 3'd1);

        // first key at or past t wins
        sel = lst;
        for (int i = 3; i >= 1; i--) begin
            if (3'(i) < cnt && t <= kt[i]) begin
                sel = 2'(i);
            end
        end
        prv = sel - 2'd1;

        wd = $signed({1'b0, kt[sel]}) - $signed({1'b0, kt[prv]});

        n_e_seg.dv  = 17'($signed({kv[sel][15], kv[sel]}) - $signed({kv[prv][15], kv[prv]}));
        n_e_seg.dtk = t - kt[prv];
        n_e_seg.w   = (wd < 17'sd1) ? 16'd1 : wd[15:0];

        n_e_cv.rec    = w_d1_rec;
        n_e_cv.apply  = r_size_en && w_d1_rec.alive;
        n_e_cv.interp = 1'b0;
        n_e_cv.neg    = 1'b0;
        n_e_cv.v0     = kv[prv];
        n_e_cv.fc     = plu_pkg::ONE_Q8_8;
        if (cnt == 3'd0) begin
            n_e_cv.fc = plu_pkg::ONE_Q8_8;
        end else if (cnt == 3'd1 || t <= kt[0]) begin
            n_e_cv.fc = {{2{kv[0][15]}}, kv[0]};
        end else if (t >= kt[lst]) begin
            n_e_cv.fc = {{2{kv[lst][15]}}, kv[lst]};
        end else begin
            n_e_cv.interp = n_e_cv.apply;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_e <= 1'b0;
        end else if (en_e) begin
            r_vld_e <= w_d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_e && w_d1_vld) begin
            r_e_cv  <= n_e_cv;
            r_e_seg <= n_e_seg;
        end
    end

    // ---------------- stage F: |dv| * (t - t0) ----------------
    plu_pkg::t_curve r_f_cv;
    logic [31:0]     r_f_prod;
    logic [15:0]     r_f_w;
    logic            w_dv_neg;
    logic [16:0]     w_dv_mag;

    assign w_dv_neg = r_e_seg.dv[16];
    assign w_dv_mag = w_dv_neg ? 17'(-r_e_seg.dv) : r_e_seg.dv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_f <= 1'b0;
        end else if (en_f) begin
            r_vld_f <= r_vld_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_f && r_vld_e) begin
            r_f_cv     <= {r_e_cv.rec, r_e_cv.apply, r_e_cv.interp, w_dv_neg,
                           r_e_cv.fc, r_e_cv.v0};
            r_f_prod   <= w_dv_mag[15:0] * r_e_seg.dtk;
            r_f_w      <= r_e_seg.w;
        end
    end

    // ---------------- interpolation divide ----------------
    logic            w_d2_vld;
    logic [15:0]     w_d2_q;
    plu_pkg::t_curve w_d2_cv;

    plu_div #(
        .DW (16),
        .QW (16),
        .PW ($bits(plu_pkg::t_curve))
    ) u_div_seg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld_f),
        .o_ready (w_d2_rdy),
        .i_rem   (r_f_prod[31:16]),
        .i_num   (r_f_prod[15:0]),
        .i_den   (r_f_w),
        .i_side  (r_f_cv),
        .o_valid (w_d2_vld),
        .i_ready (en_g),
        .o_quo   (w_d2_q),
        .o_side  (w_d2_cv)
    );

    // ---------------- stage G: curve factor ----------------
    plu_pkg::t_rec      r_g_rec;
    logic               r_g_apply;
    logic [17:0]        r_g_fct;
    logic signed [17:0] w_v0, w_q, w_fct;

    assign w_v0  = $signed({{2{w_d2_cv.v0[15]}}, w_d2_cv.v0});
    assign w_q   = $signed({2'b00, w_d2_q});
    assign w_fct = !w_d2_cv.interp ? $signed(w_d2_cv.fc)
                 : w_d2_cv.neg     ? w_v0 - w_q
                 :                   w_v0 + w_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_g <= 1'b0;
        end else if (en_g) begin
            r_vld_g <= w_d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_g && w_d2_vld) begin
            r_g_rec   <= w_d2_cv.rec;
            r_g_apply <= w_d2_cv.apply;
            r_g_fct   <= w_fct;
        end
    end

    // ---------------- stage H: size times factor ----------------
    plu_pkg::t_rec      r_h_rec;
    logic               r_h_apply;
    logic [49:0]        r_h_prod;
    logic signed [49:0] w_sz_prod;

    assign w_sz_prod = $signed(r_g_rec.size) * $signed(r_g_fct);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_h <= 1'b0;
        end else if (en_h) begin
            r_vld_h <= r_vld_g;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_h && r_vld_g) begin
            r_h_rec   <= r_g_rec;
            r_h_apply <= r_g_apply;
            r_h_prod  <= w_sz_prod;
        end
    end

    // ---------------- output register ----------------
    plu_pkg::t_rec      r_o_rec;
    logic signed [63:0] w_sz_sh;
    logic [31:0]        w_sz_o;

    assign w_sz_sh = $signed(r_h_prod) >>> 8;
    assign w_sz_o  = r_h_apply ? plu_pkg::sat32(w_sz_sh) : r_h_rec.size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_o <= 1'b0;
        end else if (en_o) begin
            r_vld_o <= r_vld_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o && r_vld_h) begin
            r_o_rec <= {r_h_rec.alive, r_h_rec.nage, r_h_rec.pos, r_h_rec.vel, w_sz_o};
        end
    end

    assign o_out_valid = r_vld_o;
    assign o_alive     = r_o_rec.alive;
    assign o_new_age   = r_o_rec.nage;
    assign o_new_pos_x = r_o_rec.pos[0];
    assign o_new_pos_y = r_o_rec.pos[1];
    assign o_new_pos_z = r_o_rec.pos[2];
    assign o_new_vel_x = r_o_rec.vel[0];
    assign o_new_vel_y = r_o_rec.vel[1];
    assign o_new_vel_z = r_o_rec.vel[2];
    assign o_new_size  = r_o_rec.size;

    `PLU_ASSERT(a_seg_span, r_vld_e && r_e_cv.interp, r_e_seg.dtk <= r_e_seg.w, "bad offset")
    `PLU_ASSERT(a_interp_live, r_vld_e && r_e_cv.interp, r_e_cv.apply && r_e_cv.rec.alive, "no curve")
    `PLU_ASSERT(a_age_cap, o_out_valid && o_alive, o_new_age != plu_pkg::AGE_MAX, "age cap alive")
    `PLU_ASSERT_NXT(a_d_hold, r_vld_d && !w_d1_rdy, r_vld_d && $stable(r_d), "motion word lost")

endmodule

@@ hw/rtl/plu_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// Uses the assertion macros header.
`include "particle_lifetime_update_macros.svh"

module plu_div #(
    parameter int DW = 16,
    parameter int QW = 16,
    parameter int PW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [PW-1:0] i_side,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [QW-1:0] o_quo,
    output logic [PW-1:0] o_side
);

    logic [QW-1:0]           r_vld;
    logic [QW-1:0][DW-1:0]   r_rem;
    logic [QW-1:0][QW-1:0]   r_num;
    logic [QW-1:0][DW-1:0]   r_den;
    logic [QW-1:0][QW-1:0]   r_quo;
    logic [QW-1:0][PW-1:0]   r_side;
    logic [QW:0]             w_en;

    assign w_en[QW] = i_ready;

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic          w_vld;
        logic [DW-1:0] w_rem;
        logic [QW-1:0] w_num;
        logic [DW-1:0] w_den;
        logic [QW-1:0] w_quo;
        logic [PW-1:0] w_side;
        logic [DW:0]   w_rr;
        logic          w_ge;
        logic [DW-1:0] n_rem;

        if (s == 0) begin : g_head
            assign w_vld  = i_valid;
            assign w_rem  = i_rem;
            assign w_num  = i_num;
            assign w_den  = i_den;
            assign w_quo  = '0;
            assign w_side = i_side;
        end else begin : g_body
            assign w_vld  = r_vld[s-1];
            assign w_rem  = r_rem[s-1];
            assign w_num  = r_num[s-1];
            assign w_den  = r_den[s-1];
            assign w_quo  = r_quo[s-1];
            assign w_side = r_side[s-1];
        end

        assign w_en[s] = !r_vld[s] || w_en[s+1];

        // shift in the next dividend bit, subtract when it fits
        assign w_rr  = {w_rem, w_num[QW-1]};
        assign w_ge  = w_rr >= {1'b0, w_den};
        assign n_rem = w_ge ? DW'(w_rr - {1'b0, w_den}) : w_rr[DW-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (w_en[s]) begin
                r_vld[s] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[s] && w_vld) begin
                r_rem[s]  <= n_rem;
                r_num[s]  <= w_num << 1;
                r_den[s]  <= w_den;
                r_quo[s]  <= (w_quo << 1) | QW'(w_ge);
                r_side[s] <= w_side;
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_side[QW-1];

    `PLU_ASSERT_NXT(a_div_take, i_valid && w_en[0], r_vld[0], "divider dropped a new word")
    `PLU_ASSERT_NXT(a_div_head_hold, r_vld[0] && !w_en[0], r_vld[0] && $stable(r_rem[0]), "first divider stage lost its word")
    `PLU_ASSERT_NXT(a_div_tail_hold, r_vld[QW-1] && !i_ready, r_vld[QW-1] && $stable(r_quo[QW-1]), "stalled quotient changed")

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for particle_lifetime_update: drives particle records
// and config writes, predicts each result word and compares it. Needs plu_pkg.
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        logic [30:0]        step;
        logic [30:0]        age;
        logic [30:0]        life;
        logic signed [31:0] pos [3];
        logic signed [31:0] vel [3];
        logic signed [31:0] size;
    } t_particle;

    typedef struct {
        logic               alive;
        logic [30:0]        nage;
        logic signed [31:0] pos [3];
        logic signed [31:0] vel [3];
        logic signed [31:0] size;
    } t_update;

    class particle_scoreboard;
        logic signed [31:0] grav [3];
        bit                 size_en;
        bit [2:0]           key_cnt;
        bit [63:0]          key_t;
        bit [63:0]          key_v;
        t_update            pending [$];
        int                 errors;

        function new();
            grav[0] = 0;
            grav[1] = plu_pkg::GRAV_Y_RST;
            grav[2] = 0;
            size_en = 0;
            key_cnt = 0;
            key_t = 0;
            key_v = 0;
            errors = 0;
        endfunction

        function void write_reg(plu_pkg::t_cfg_idx idx, bit [63:0] d);
            case (idx)
                plu_pkg::CFG_GRAV_X:     grav[0] = d[31:0];
                plu_pkg::CFG_GRAV_Y:     grav[1] = d[31:0];
                plu_pkg::CFG_GRAV_Z:     grav[2] = d[31:0];
                plu_pkg::CFG_SIZE_EN:    size_en = d[0];
                plu_pkg::CFG_KEY_COUNT:  key_cnt = d[2:0];
                plu_pkg::CFG_KEY_TIMES:  key_t = d;
                plu_pkg::CFG_KEY_VALUES: key_v = d;
                default: ;
            endcase
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint ktime(int k);
            return longint'(key_t[16*k +: 16]);
        endfunction

        function longint kval(int k);
            logic signed [15:0] v;
            v = key_v[16*k +: 16];
            return longint'(v);
        endfunction

        // size factor in Q8.8 at normalized age t (Q0.16)
        function longint size_gain(longint t);
            int     n;
            longint t0, w;
            n = (key_cnt > 4) ? 4 : key_cnt;
            if (n == 0) return 256;
            if (n == 1) return kval(0);
            if (t <= ktime(0)) return kval(0);
            if (t >= ktime(n - 1)) return kval(n - 1);
            for (int i = 1; i < n; i++) begin
                if (t <= ktime(i)) begin
                    t0 = ktime(i - 1);
                    w = ktime(i) - t0;
                    if (w < 1) w = 1;
                    return kval(i - 1) + ((kval(i) - kval(i - 1)) * (t - t0)) / w;
                end
            end
            return kval(n - 1);
        endfunction

        function void note_word(t_particle p);
            longint  dt, nage, lf, v, x, sz, t;
            t_update r;
            dt = p.step;
            lf = p.life;
            nage = longint'(p.age) + dt;
            if (nage > 64'h7FFF_FFFF) nage = 64'h7FFF_FFFF;
            r.alive = (nage < lf);
            r.nage = nage[30:0];
            sz = p.size;
            for (int k = 0; k < 3; k++) begin
                r.pos[k] = p.pos[k];
                r.vel[k] = p.vel[k];
            end
            if (r.alive) begin
                for (int k = 0; k < 3; k++) begin
                    v = clamp32(longint'(p.vel[k]) + ((longint'(grav[k]) * dt) >>> 16));
                    x = clamp32(longint'(p.pos[k]) + ((v * dt) >>> 16));
                    r.vel[k] = v[31:0];
                    r.pos[k] = x[31:0];
                end
                if (size_en) begin
                    t = (nage << 16) / lf;
                    sz = clamp32((sz * size_gain(t)) >>> 8);
                end
            end
            r.size = sz[31:0];
            pending = {pending, r};
        endfunction

        function void cmp(string name, longint e, longint a);
            if (e != a) begin
                $error("%s: expected %0d, got %0d", name, e, a);
                errors++;
            end
        endfunction

        function void check_word(t_update a);
            t_update e;
            if (pending.size() == 0) begin
                $error("result word with no particle pending");
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp("alive", e.alive, a.alive);
            cmp("new_age", e.nage, a.nage);
            cmp("new_pos_x", e.pos[0], a.pos[0]);
            cmp("new_pos_y", e.pos[1], a.pos[1]);
            cmp("new_pos_z", e.pos[2], a.pos[2]);
            cmp("new_vel_x", e.vel[0], a.vel[0]);
            cmp("new_vel_y", e.vel[1], a.vel[1]);
            cmp("new_vel_z", e.vel[2], a.vel[2]);
            cmp("new_size", e.size, a.size);
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [63:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [30:0]        i_step_time;
    logic [30:0]        i_age;
    logic [30:0]        i_life_span;
    logic signed [31:0] i_pos_x, i_pos_y, i_pos_z;
    logic signed [31:0] i_vel_x, i_vel_y, i_vel_z;
    logic signed [31:0] i_initial_size;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_alive;
    logic [30:0]        o_new_age;
    logic signed [31:0] o_new_pos_x, o_new_pos_y, o_new_pos_z;
    logic signed [31:0] o_new_vel_x, o_new_vel_y, o_new_vel_z;
    logic signed [31:0] o_new_size;

    particle_lifetime_update uut (.*);

    particle_scoreboard sb = new();
    int  send_idle_pct;
    int  recv_stall_pct;
    int  cycles = 0;

    localparam int CYCLE_LIMIT = 400000;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // random backpressure on the result side; check every accepted word
    always @(posedge i_clk) begin
        t_update r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            r.alive = o_alive;
            r.nage = o_new_age;
            r.pos[0] = o_new_pos_x;
            r.pos[1] = o_new_pos_y;
            r.pos[2] = o_new_pos_z;
            r.vel[0] = o_new_vel_x;
            r.vel[1] = o_new_vel_y;
            r.vel[2] = o_new_vel_z;
            r.size = o_new_size;
            sb.check_word(r);
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // call at a clock edge; returns at the edge where the write is taken
    task automatic write_reg(plu_pkg::t_cfg_idx idx, bit [63:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, d);
    endtask

    task automatic load_config(bit [31:0] gx, bit [31:0] gy, bit [31:0] gz, bit en,
                               bit [2:0] cnt, bit [63:0] kt, bit [63:0] kv);
        write_reg(plu_pkg::CFG_GRAV_X, {32'h0, gx});
        write_reg(plu_pkg::CFG_GRAV_Y, {32'h0, gy});
        write_reg(plu_pkg::CFG_GRAV_Z, {32'h0, gz});
        write_reg(plu_pkg::CFG_SIZE_EN, {63'h0, en});
        write_reg(plu_pkg::CFG_KEY_COUNT, {61'h0, cnt});
        write_reg(plu_pkg::CFG_KEY_TIMES, kt);
        write_reg(plu_pkg::CFG_KEY_VALUES, kv);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // call at a clock edge; returns at the edge where the word is taken
    task automatic send_word(t_particle p);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_step_time <= p.step;
        i_age <= p.age;
        i_life_span <= p.life;
        i_pos_x <= p.pos[0];
        i_pos_y <= p.pos[1];
        i_pos_z <= p.pos[2];
        i_vel_x <= p.vel[0];
        i_vel_y <= p.vel[1];
        i_vel_z <= p.vel[2];
        i_initial_size <= p.size;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_word(p);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (45) @(posedge i_clk);
    endtask

    function automatic bit [31:0] any_signed();
        case ($urandom_range(5))
            0, 1: return $urandom;
            2: return 32'h7FFF_FFFF - $urandom_range(3);
            3: return 32'h8000_0000 + $urandom_range(3);
            default: return $urandom >>> $urandom_range(31);
        endcase
    endfunction

    function automatic bit [30:0] masked31();
        return 31'($urandom >> $urandom_range(1, 31));
    endfunction

    function automatic t_particle random_particle();
        t_particle p;
        for (int k = 0; k < 3; k++) begin
            p.pos[k] = any_signed();
            p.vel[k] = any_signed();
        end
        p.size = any_signed();
        if ($urandom_range(9) < 2) begin
            p.step = 31'($urandom);
            p.age = 31'($urandom);
            p.life = 31'($urandom);
        end else begin
            // mostly live particles: age below the life span, step derived from the remaining life
            p.life = masked31();
            if (p.life == 0) p.life = 1;
            p.age = 31'($urandom % p.life);
            p.step = (p.life - p.age) >> $urandom_range(0, 8);
            if ($urandom_range(3) == 0) p.step = 31'(p.step + $urandom_range(2));
        end
        return p;
    endfunction

    function automatic bit [63:0] random_times();
        bit [15:0] k [4];
        bit [15:0] s;
        for (int i = 0; i < 4; i++) k[i] = 16'($urandom);
        case ($urandom_range(3))
            0: ;  // unordered times
            1: begin
                k[2] = k[1];
                k[1] = k[0];
            end
            default: begin
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3 - i; j++)
                        if (k[j] > k[j+1]) begin
                            s = k[j];
                            k[j] = k[j+1];
                            k[j+1] = s;
                        end
            end
        endcase
        return {k[3], k[2], k[1], k[0]};
    endfunction

    task automatic run_directed();
        t_particle p;
        p = random_particle();
        for (int n = 0; n < 20; n++) begin
            p = random_particle();
            case (n)
                0: begin p.step = 0; p.age = 0; p.life = 1; end
                1: begin p.step = 31'h7FFF_FFFF; p.age = 31'h7FFF_FFFF; end
                2: begin p.life = 0; p.age = 0; p.step = 0; end
                3: begin p.step = 31'h7FFF_FFFF; p.age = 0; p.life = 31'h7FFF_FFFF; end
                4: begin p.step = 1; p.age = 31'h7FFF_FFFD; p.life = 31'h7FFF_FFFF; end
                5: begin p.step = 10; p.age = 20; p.life = 30; end
                6: begin
                    p.step = 31'h0001_0000; p.age = 0; p.life = 31'h7FFF_FFFF;
                    p.pos = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
                    p.vel = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000};
                    p.size = 32'h7FFF_FFFF;
                end
                7: begin
                    p.step = 31'h7FFF_0000; p.age = 0; p.life = 31'h7FFF_FFFF;
                    p.pos = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0};
                    p.vel = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h1};
                    p.size = 32'h8000_0000;
                end
                8: begin p.step = 1; p.age = 0; p.life = 31'h7FFF_FFFF; p.size = -1; end
                9: begin p.step = 0; p.age = 0; p.life = 5; end
                10: begin p.step = 0; p.age = 31'h7FFF_FFFE; p.life = 31'h7FFF_FFFF; end
                11: begin p.step = 3; p.age = 4; p.life = 7; end
                default: ;
            endcase
            send_word(p);
        end
    endtask

    initial begin
        t_particle p;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = plu_pkg::CFG_GRAV_X;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_step_time = '0;
        i_age = '0;
        i_life_span = 31'd1;
        {i_pos_x, i_pos_y, i_pos_z} = '0;
        {i_vel_x, i_vel_y, i_vel_z} = '0;
        i_initial_size = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config first, then a full curve with extreme values
        run_directed();
        drain();
        load_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 1'b1, 3'd4,
                    {16'hFFFF, 16'hC000, 16'h4000, 16'h0000},
                    {16'h7FFF, 16'h8000, 16'h0100, 16'hFF00});
        run_directed();
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            case (ph)
                0: load_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 3'd7,
                               random_times(), {$urandom, $urandom});
                1: load_config(32'h0, 32'h0, 32'h0, 1'b0, 3'd0, 64'h0, 64'h0);
                2: load_config(any_signed(), any_signed(), any_signed(), 1'b1, 3'd0,
                               random_times(), {$urandom, $urandom});
                3: load_config(any_signed(), any_signed(), any_signed(), 1'b1, 3'd1,
                               random_times(), {$urandom, $urandom});
                default: load_config(any_signed(), any_signed(), any_signed(), 1'b1,
                                     3'($urandom_range(2, 7)), random_times(),
                                     {$urandom, $urandom});
            endcase
            for (int n = 0; n < 215; n++) begin
                p = random_particle();
                send_word(p);
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/plu_pkg.sv
hw/rtl/plu_div.sv
hw/rtl/particle_lifetime_update.sv
dv/tb_top.sv
